// ===== design/kwsc_pkg.sv =====
package kwsc_pkg;

  localparam int ALPHA_SIZE = 26;

  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;

  // request kind codes as they appear on the input channel
  localparam logic [2:0] KIND_CLEAR    = 3'd0;
  localparam logic [2:0] KIND_ADD      = 3'd1;
  localparam logic [2:0] KIND_FINALIZE = 3'd2;
  localparam logic [2:0] KIND_ENCRYPT  = 3'd3;
  localparam logic [2:0] KIND_DECRYPT  = 3'd4;

  // response status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_READY = 2'd1;
  localparam logic [1:0] ST_IGNORED   = 2'd2;

  // operation class after decode; unused kind codes become OP_NONE
  typedef enum logic [2:0] {
    OP_CLEAR,
    OP_ADD,
    OP_FINALIZE,
    OP_ENCRYPT,
    OP_DECRYPT,
    OP_NONE
  } op_t;

  // decoded item carried from the front end to the back end
  typedef struct packed {
    op_t        op;
    logic       letter;
    logic       upper;
    logic [4:0] idx;
    logic [7:0] code;
  } item_t;

endpackage

// ===== design/kwsc_if.sv =====
interface kwsc_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] char_code;

  modport source (output valid, output kind, output char_code, input ready);
  modport sink (input valid, input kind, input char_code, output ready);
endinterface

interface kwsc_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic [1:0] status;

  modport source (output valid, output char_out, output status, input ready);
  modport sink (input valid, input char_out, input status, output ready);
endinterface

// ===== design/kwsc_front.sv =====
module kwsc_front
  import kwsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  kwsc_req_if.sink    req,
  output logic        push_valid,
  input  logic        push_ready,
  output item_t       push_item
);

  logic  held;
  item_t item;
  item_t decoded;
  logic  is_lower;
  logic  is_upper;

  // classify the incoming character and kind
  always_comb begin
    is_lower = (req.char_code >= CHAR_LOWER_A) &&
               (req.char_code < CHAR_LOWER_A + 8'(ALPHA_SIZE));
    is_upper = (req.char_code >= CHAR_UPPER_A) &&
               (req.char_code < CHAR_UPPER_A + 8'(ALPHA_SIZE));
    decoded.code   = req.char_code;
    decoded.letter = is_lower || is_upper;
    decoded.upper  = is_upper;
    decoded.idx    = is_upper ? 5'(req.char_code - CHAR_UPPER_A)
                              : 5'(req.char_code - CHAR_LOWER_A);
    unique case (req.kind)
      KIND_CLEAR:    decoded.op = OP_CLEAR;
      KIND_ADD:      decoded.op = OP_ADD;
      KIND_FINALIZE: decoded.op = OP_FINALIZE;
      KIND_ENCRYPT:  decoded.op = OP_ENCRYPT;
      KIND_DECRYPT:  decoded.op = OP_DECRYPT;
      default:       decoded.op = OP_NONE;
    endcase
  end

  assign req.ready  = !held || push_ready;
  assign push_valid = held;
  assign push_item  = item;

  // hold one decoded beat until the queue takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (req.valid && req.ready) begin
      held <= 1'b1;
    end else if (push_ready) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      item <= decoded;
    end
  end

endmodule

// ===== design/kwsc_queue.sv =====
module kwsc_queue
  import kwsc_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  output logic  push_ready,
  input  item_t push_item,
  output logic  pop_valid,
  input  logic  pop,
  output item_t pop_item
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t          slots [DEPTH];
  logic [PW-1:0]  wptr;
  logic [PW-1:0]  rptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign push_ready = count != CW'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_item   = slots[rptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  // advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= push_item;
    end
  end

endmodule

// ===== design/kwsc_back.sv =====
module kwsc_back
  import kwsc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  output logic       q_pop,
  input  item_t      q_item,
  kwsc_rsp_if.source rsp
);

  typedef enum logic [1:0] {
    S_RUN  = 2'b01,
    S_FILL = 2'b10
  } state_t;

  state_t                  state;
  logic [4:0]              fwd_tbl [ALPHA_SIZE];
  logic [4:0]              inv_tbl [ALPHA_SIZE];
  logic [ALPHA_SIZE-1:0]   used;
  logic [4:0]              key_len;
  logic                    key_ready;
  logic [4:0]              fill_idx;
  logic                    out_valid;
  logic [7:0]              out_char;
  logic [1:0]              out_status;

  logic       out_free;
  logic       out_load;
  logic       fill_last;
  logic       fill_step;
  logic       place_en;
  logic [4:0] place_letter;
  logic [7:0] base;
  logic [7:0] run_char;
  logic [1:0] run_status;

  assign out_free  = !out_valid || rsp.ready;
  assign fill_last = fill_idx == 5'(ALPHA_SIZE - 1);
  assign fill_step = (state == S_FILL) && (!fill_last || out_free);
  assign q_pop     = (state == S_RUN) && q_valid && out_free;
  assign out_load  = (q_pop && q_item.op != OP_FINALIZE) || (fill_step && fill_last);
  assign base      = q_item.upper ? CHAR_UPPER_A : CHAR_LOWER_A;

  assign rsp.valid    = out_valid;
  assign rsp.char_out = out_char;
  assign rsp.status   = out_status;

  // pick the letter to place in the next free table slot
  always_comb begin
    place_en     = 1'b0;
    place_letter = q_item.idx;
    if (q_pop && q_item.op == OP_ADD && q_item.letter) begin
      place_en = !used[q_item.idx] && (key_len < 5'(ALPHA_SIZE));
    end else if (fill_step) begin
      place_letter = fill_idx;
      place_en     = !used[fill_idx] && (key_len < 5'(ALPHA_SIZE));
    end
  end

  // result of a beat taken from the queue
  always_comb begin
    run_char   = 8'd0;
    run_status = ST_OK;
    unique case (q_item.op)
      OP_ADD: begin
        if (!q_item.letter) run_status = ST_IGNORED;
      end
      OP_ENCRYPT, OP_DECRYPT: begin
        if (!key_ready) begin
          run_char   = q_item.code;
          run_status = ST_NOT_READY;
        end else if (!q_item.letter) begin
          run_char = q_item.code;
        end else if (q_item.op == OP_ENCRYPT) begin
          run_char = base + {3'b000, fwd_tbl[q_item.idx]};
        end else begin
          run_char = base + {3'b000, inv_tbl[q_item.idx]};
        end
      end
      default: begin
        run_char   = 8'd0;
        run_status = ST_OK;
      end
    endcase
  end

  // control: execute, sweep the alphabet on finalize, drive the result
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_RUN;
      used      <= '0;
      key_len   <= '0;
      key_ready <= 1'b0;
      fill_idx  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (place_en) begin
        used[place_letter] <= 1'b1;
        key_len            <= key_len + 1'b1;
      end
      unique case (state)
        S_RUN: begin
          if (q_pop) begin
            if (q_item.op == OP_FINALIZE) begin
              state    <= S_FILL;
              fill_idx <= '0;
            end else if (q_item.op == OP_CLEAR) begin
              used      <= '0;
              key_len   <= '0;
              key_ready <= 1'b0;
            end
          end
        end
        S_FILL: begin
          if (fill_step) begin
            if (fill_last) begin
              state     <= S_RUN;
              fill_idx  <= '0;
              key_ready <= 1'b1;
            end else begin
              fill_idx <= fill_idx + 1'b1;
            end
          end
        end
        default: begin
          state <= S_RUN;
        end
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (q_pop && q_item.op != OP_FINALIZE) begin
      out_char   <= run_char;
      out_status <= run_status;
    end else if (fill_step && fill_last) begin
      out_char   <= 8'd0;
      out_status <= ST_OK;
    end
  end

  // key tables: forward by position, inverse by letter
  always_ff @(posedge clk) begin
    if (place_en) begin
      fwd_tbl[key_len]      <= place_letter;
      inv_tbl[place_letter] <= key_len;
    end
  end

endmodule

// ===== design/keyword_substitution_cipher.sv =====
// Keyword substitution cipher on a character stream.
// req channel: kind (0 clear, 1 add key letter, 2 finalize, 3 encrypt,
// 4 decrypt) and char_code. rsp channel: one beat per request with
// char_out (zero for key operations) and status (0 ok, 1 key not
// finalized so the character passed, 2 key character ignored).
// Letter case is kept; non-letters pass unchanged.
// Path: decode register, then queue, then back-end result register.
// Throughput: one beat per cycle for clear, add, encrypt and decrypt
// while the receiver keeps up. A finalize holds the back end while it
// sweeps the alphabet one letter a cycle, the last once the result
// register is free, to fill the table; the queue of QUEUE_DEPTH decoded
// beats keeps taking requests meanwhile.
// Reset clears the key (no letters used, not finalized) and empties the
// queue and the result register; no request is lost or answered twice.
// When the receiver stalls, the result beat holds, the back end stops,
// and req.ready drops once the queue and decode register are full.
module keyword_substitution_cipher
  import kwsc_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  kwsc_req_if.sink   req,
  kwsc_rsp_if.source rsp
);

  logic  push_valid;
  logic  push_ready;
  item_t push_item;
  logic  pop_valid;
  logic  pop;
  item_t pop_item;

  kwsc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  kwsc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_item   (pop_item)
  );

  kwsc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (pop_valid),
    .q_pop   (pop),
    .q_item  (pop_item),
    .rsp     (rsp)
  );

endmodule

// ===== design/kwsc_checker.sv =====
module kwsc_checker
  import kwsc_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [7:0] rsp_char_out,
  input logic [1:0] rsp_status
);

  // a waiting result stays offered until taken
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  // nothing is offered right after reset
  assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  // status is always a defined code
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_status == ST_OK || rsp_status == ST_NOT_READY ||
                   rsp_status == ST_IGNORED))
    else $error("undefined status code");

  // an ignored key character answers with a zero character
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == ST_IGNORED |-> rsp_char_out == 8'd0)
    else $error("ignored key character returned data");

endmodule

bind keyword_substitution_cipher kwsc_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .rsp_char_out (rsp.char_out),
  .rsp_status   (rsp.status)
);
